// ===== hw/rtl/lssf_pkg.sv =====
// shared types, constants and register indexes for the laser scan shadow filter
// no dependencies; imported by every module of the block
package lssf_pkg;

    localparam int RANGE_W     = 16;
    localparam int INT_W       = 16;
    localparam int MAX_POINTS  = 2048;
    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int TDATA_W     = RANGE_W + INT_W;

    localparam logic [CFG_IDX_W-1:0] REG_RNG_LO     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RNG_HI     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_FIRST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_LAST   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COS_STEP   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd6;

    localparam logic [RANGE_W-1:0]  RST_RNG_LO    = 16'd0;
    localparam logic [RANGE_W-1:0]  RST_RNG_HI    = 16'd65535;
    localparam logic [RANGE_W-1:0]  RST_MAX_DIST  = 16'd65535;
    localparam logic [IDX_W-1:0]    RST_WIN_FIRST = IDX_W'(0);
    localparam logic [IDX_W-1:0]    RST_WIN_LAST  = IDX_W'(MAX_POINTS - 1);
    localparam logic signed [15:0]  RST_COS_STEP  = 16'sd16383;
    localparam logic [15:0]         RST_THRESHOLD = 16'd64225;

    typedef struct packed {
        logic [RANGE_W-1:0]  rng_lo;
        logic [RANGE_W-1:0]  rng_hi;
        logic [RANGE_W-1:0]  max_dist;
        logic [IDX_W-1:0]    win_first;
        logic [IDX_W-1:0]    win_last;
        logic signed [15:0]  cos_step;
        logic [15:0]         threshold;
    } cfg_t;

    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic [INT_W-1:0]   intensity;
        logic               valid;
        logic               last;
    } item_t;

    typedef struct packed {
        logic               start;
        logic [RANGE_W-1:0] a;
        logic [RANGE_W-1:0] b;
    } sh_req_t;

    typedef struct packed {
        logic done;
        logic hit;
    } sh_rsp_t;

endpackage

// ===== hw/rtl/lssf_front.sv =====
// front end: accepts input transactions, tracks the sample index, classifies validity
// depends on lssf_pkg; feeds lssf_queue
module lssf_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lssf_pkg::cfg_t                cfg,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lssf_pkg::TDATA_W-1:0]  s_axis_tdata,
    input  logic                          s_axis_tuser,
    input  logic                          s_axis_tlast,
    input  logic                          q_full,
    output logic                          push,
    output lssf_pkg::item_t               push_item
);
    import lssf_pkg::*;

    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic [RANGE_W-1:0] rng;
    logic               valid;

    assign rng           = s_axis_tdata[RANGE_W-1:0];
    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && s_axis_tready;

    assign valid = !s_axis_tuser
                && (rng >= cfg.rng_lo) && (rng <= cfg.rng_hi)
                && (rng <= cfg.max_dist)
                && (idx_reg >= cfg.win_first) && (idx_reg <= cfg.win_last);

    always_comb
    begin
        push_item.range_mm  = rng;
        push_item.intensity = s_axis_tdata[TDATA_W-1:RANGE_W];
        push_item.valid     = valid;
        push_item.last      = s_axis_tlast;
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (push)
        begin
            if (s_axis_tlast)
                idx_next = '0;
            else if (idx_reg != IDX_W'(MAX_POINTS - 1))
                idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

endmodule

// ===== hw/rtl/lssf_queue.sv =====
// short queue of classified samples between the front and back ends
// depends on lssf_pkg
module lssf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lssf_pkg::item_t push_item,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output lssf_pkg::item_t head
);
    import lssf_pkg::*;

    item_t               slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;

    assign full  = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== hw/rtl/lssf_shadow.sv =====
// multi-cycle shadow test on one pair of ranges with a shared 32x32 multiplier
// depends on lssf_pkg; started and read by lssf_back
module lssf_shadow (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lssf_pkg::sh_req_t      req,
    input  logic signed [15:0]     cos_step,
    input  logic [15:0]            threshold,
    output lssf_pkg::sh_rsp_t      rsp
);
    import lssf_pkg::*;

    localparam logic [3:0] SH_IDLE = 4'd0;
    localparam logic [3:0] SH_AA   = 4'd1;
    localparam logic [3:0] SH_BB   = 4'd2;
    localparam logic [3:0] SH_AB   = 4'd3;
    localparam logic [3:0] SH_XM   = 4'd4;
    localparam logic [3:0] SH_PQ   = 4'd5;
    localparam logic [3:0] SH_CHK  = 4'd6;
    localparam logic [3:0] SH_TP1  = 4'd7;
    localparam logic [3:0] SH_TP2  = 4'd8;
    localparam logic [3:0] SH_TQ1  = 4'd9;
    localparam logic [3:0] SH_TQ2  = 4'd10;
    localparam logic [3:0] SH_M0   = 4'd11;
    localparam logic [3:0] SH_M1   = 4'd12;
    localparam logic [3:0] SH_M2   = 4'd13;
    localparam logic [3:0] SH_M3   = 4'd14;
    localparam logic [3:0] SH_CMP  = 4'd15;

    logic [3:0]         step_reg;
    logic [3:0]         step_next;
    logic               done_reg;
    logic               done_next;
    logic               hit_reg;
    logic               hit_next;

    logic [RANGE_W-1:0] a_reg;
    logic [RANGE_W-1:0] b_reg;
    logic [15:0]        cmag_reg;
    logic [15:0]        t_reg;
    logic [63:0]        prod_reg;
    logic [31:0]        a2_reg;
    logic [31:0]        b2_reg;
    logic [32:0]        s_reg;
    logic [31:0]        n_reg;
    logic [63:0]        n2_reg;
    logic [48:0]        plus_reg;
    logic [48:0]        minus_reg;
    logic [47:0]        tp_lo_reg;
    logic [63:0]        tp_reg;
    logic [47:0]        tq_lo_reg;
    logic [63:0]        tq_reg;
    logic [127:0]       acc_reg;

    logic [31:0]        mul_x;
    logic [31:0]        mul_y;
    logic [63:0]        mul_p;
    logic [48:0]        s_sh;
    logic [48:0]        xm;
    logic               pq_pos;
    logic [127:0]       lhs;

    assign mul_p  = mul_x * mul_y;
    assign s_sh   = {3'b000, s_reg, 13'b0};
    assign xm     = {1'b0, prod_reg[47:0]};
    assign pq_pos = !minus_reg[48] && (|minus_reg) && (|plus_reg);
    assign lhs    = {6'b0, n2_reg, 58'b0};
    assign rsp.done = done_reg;
    assign rsp.hit  = hit_reg;

    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        case (step_reg)
            SH_AA:
            begin
                mul_x = {16'b0, a_reg};
                mul_y = {16'b0, a_reg};
            end
            SH_BB:
            begin
                mul_x = {16'b0, b_reg};
                mul_y = {16'b0, b_reg};
            end
            SH_AB:
            begin
                mul_x = {16'b0, a_reg};
                mul_y = {16'b0, b_reg};
            end
            SH_XM:
            begin
                mul_x = prod_reg[31:0];
                mul_y = {16'b0, cmag_reg};
            end
            SH_PQ:
            begin
                mul_x = n_reg;
                mul_y = n_reg;
            end
            SH_CHK:
            begin
                mul_x = {16'b0, t_reg};
                mul_y = minus_reg[31:0];
            end
            SH_TP1:
            begin
                mul_x = {16'b0, t_reg};
                mul_y = {16'b0, minus_reg[47:32]};
            end
            SH_TP2:
            begin
                mul_x = {16'b0, t_reg};
                mul_y = plus_reg[31:0];
            end
            SH_TQ1:
            begin
                mul_x = {16'b0, t_reg};
                mul_y = {16'b0, plus_reg[47:32]};
            end
            SH_TQ2:
            begin
                mul_x = tp_reg[31:0];
                mul_y = tq_lo_reg[31:0];
            end
            SH_M0:
            begin
                mul_x = tp_reg[31:0];
                mul_y = tq_reg[63:32];
            end
            SH_M1:
            begin
                mul_x = tp_reg[63:32];
                mul_y = tq_reg[31:0];
            end
            SH_M2:
            begin
                mul_x = tp_reg[63:32];
                mul_y = tq_reg[63:32];
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        done_next = 1'b0;
        hit_next  = hit_reg;
        case (step_reg)
            SH_IDLE: if (req.start) step_next = SH_AA;
            SH_AA:   step_next = SH_BB;
            SH_BB:   step_next = SH_AB;
            SH_AB:   step_next = SH_XM;
            SH_XM:   step_next = SH_PQ;
            SH_PQ:   step_next = SH_CHK;
            SH_CHK:
            begin
                if (pq_pos)
                    step_next = SH_TP1;
                else
                begin
                    step_next = SH_IDLE;
                    done_next = 1'b1;
                    hit_next  = 1'b0;
                end
            end
            SH_TP1:  step_next = SH_TP2;
            SH_TP2:  step_next = SH_TQ1;
            SH_TQ1:  step_next = SH_TQ2;
            SH_TQ2:  step_next = SH_M0;
            SH_M0:   step_next = SH_M1;
            SH_M1:   step_next = SH_M2;
            SH_M2:   step_next = SH_M3;
            SH_M3:   step_next = SH_CMP;
            SH_CMP:
            begin
                step_next = SH_IDLE;
                done_next = 1'b1;
                hit_next  = (lhs > acc_reg);
            end
            default: step_next = SH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= SH_IDLE;
            done_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
            hit_reg  <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        case (step_reg)
            SH_IDLE:
            begin
                if (req.start)
                begin
                    a_reg    <= req.a;
                    b_reg    <= req.b;
                    cmag_reg <= cos_step[15] ? 16'(-cos_step) : cos_step;
                    t_reg    <= threshold;
                end
            end
            SH_BB:  a2_reg <= prod_reg[31:0];
            SH_AB:  b2_reg <= prod_reg[31:0];
            SH_XM:
            begin
                s_reg <= {1'b0, a2_reg} + {1'b0, b2_reg};
                n_reg <= (b2_reg >= a2_reg) ? (b2_reg - a2_reg) : (a2_reg - b2_reg);
            end
            SH_PQ:
            begin
                plus_reg  <= s_sh + xm;
                minus_reg <= s_sh - xm;
            end
            SH_CHK: n2_reg <= prod_reg;
            SH_TP1: tp_lo_reg <= prod_reg[47:0];
            SH_TP2: tp_reg <= {16'b0, tp_lo_reg} + {prod_reg[31:0], 32'b0};
            SH_TQ1: tq_lo_reg <= prod_reg[47:0];
            SH_TQ2: tq_reg <= {16'b0, tq_lo_reg} + {prod_reg[31:0], 32'b0};
            SH_M0:  acc_reg <= {64'b0, prod_reg};
            SH_M1:  acc_reg <= acc_reg + {32'b0, prod_reg, 32'b0};
            SH_M2:  acc_reg <= acc_reg + {32'b0, prod_reg, 32'b0};
            SH_M3:  acc_reg <= acc_reg + {prod_reg, 64'b0};
            default:
            begin
            end
        endcase
    end

endmodule

// ===== hw/rtl/lssf_back.sv =====
// back end: pairs neighboring samples, runs the shadow test, emits results
// depends on lssf_pkg and lssf_shadow; drains lssf_queue
module lssf_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lssf_pkg::cfg_t               cfg,
    input  logic                         q_empty,
    input  lssf_pkg::item_t              head,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [lssf_pkg::RANGE_W-1:0] out_range_mm,
    output logic                         out_filtered,
    output logic [lssf_pkg::INT_W-1:0]   out_intensity,
    output logic                         out_eos
);
    import lssf_pkg::*;

    localparam logic [1:0] BK_IDLE = 2'd0;
    localparam logic [1:0] BK_TEST = 2'd1;
    localparam logic [1:0] BK_HELD = 2'd2;
    localparam logic [1:0] BK_CUR  = 2'd3;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    item_t              cur_reg;
    item_t              cur_next;
    logic               shad_reg;
    logic               shad_next;

    logic [RANGE_W-1:0] held_range_reg;
    logic [RANGE_W-1:0] held_range_next;
    logic [INT_W-1:0]   held_int_reg;
    logic [INT_W-1:0]   held_int_next;
    logic               held_valid_reg;
    logic               held_valid_next;
    logic               held_shad_reg;
    logic               held_shad_next;
    logic               held_present_reg;
    logic               held_present_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [RANGE_W-1:0] out_range_reg;
    logic [RANGE_W-1:0] out_range_next;
    logic               out_filt_reg;
    logic               out_filt_next;
    logic [INT_W-1:0]   out_int_reg;
    logic [INT_W-1:0]   out_int_next;
    logic               out_eos_reg;
    logic               out_eos_next;
    logic               out_free;

    sh_req_t            sh_req;
    sh_rsp_t            sh_rsp;

    lssf_shadow u_shadow (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (sh_req),
        .cos_step  (cfg.cos_step),
        .threshold (cfg.threshold),
        .rsp       (sh_rsp)
    );

    assign out_free      = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_range_mm  = out_range_reg;
    assign out_filtered  = out_filt_reg;
    assign out_intensity = out_int_reg;
    assign out_eos       = out_eos_reg;

    always_comb
    begin
        state_next        = state_reg;
        cur_next          = cur_reg;
        shad_next         = shad_reg;
        held_range_next   = held_range_reg;
        held_int_next     = held_int_reg;
        held_valid_next   = held_valid_reg;
        held_shad_next    = held_shad_reg;
        held_present_next = held_present_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_range_next    = out_range_reg;
        out_filt_next     = out_filt_reg;
        out_int_next      = out_int_reg;
        out_eos_next      = out_eos_reg;
        pop               = 1'b0;
        sh_req.start      = 1'b0;
        sh_req.a          = held_range_reg;
        sh_req.b          = head.range_mm;

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop       = 1'b1;
                    cur_next  = head;
                    shad_next = 1'b0;
                    if (held_present_reg && held_valid_reg && head.valid)
                    begin
                        sh_req.start = 1'b1;
                        state_next   = BK_TEST;
                    end
                    else if (held_present_reg)
                        state_next = BK_HELD;
                    else if (head.last)
                        state_next = BK_CUR;
                    else
                    begin
                        held_range_next   = head.range_mm;
                        held_int_next     = head.intensity;
                        held_valid_next   = head.valid;
                        held_shad_next    = 1'b0;
                        held_present_next = 1'b1;
                    end
                end
            end
            BK_TEST:
            begin
                if (sh_rsp.done)
                begin
                    shad_next = sh_rsp.hit;
                    if (sh_rsp.hit)
                        held_shad_next = 1'b1;
                    state_next = BK_HELD;
                end
            end
            BK_HELD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_filt_next  = !held_valid_reg || held_shad_reg;
                    out_range_next = (!held_valid_reg || held_shad_reg) ? '0 : held_range_reg;
                    out_int_next   = held_shad_reg ? '0 : held_int_reg;
                    out_eos_next   = 1'b0;
                    if (cur_reg.last)
                        state_next = BK_CUR;
                    else
                    begin
                        held_range_next   = cur_reg.range_mm;
                        held_int_next     = cur_reg.intensity;
                        held_valid_next   = cur_reg.valid;
                        held_shad_next    = shad_reg;
                        held_present_next = 1'b1;
                        state_next        = BK_IDLE;
                    end
                end
            end
            BK_CUR:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_filt_next     = !cur_reg.valid || shad_reg;
                    out_range_next    = (!cur_reg.valid || shad_reg) ? '0 : cur_reg.range_mm;
                    out_int_next      = shad_reg ? '0 : cur_reg.intensity;
                    out_eos_next      = 1'b1;
                    held_range_next   = '0;
                    held_int_next     = '0;
                    held_valid_next   = 1'b0;
                    held_shad_next    = 1'b0;
                    held_present_next = 1'b0;
                    state_next        = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_IDLE;
            shad_reg         <= 1'b0;
            held_range_reg   <= '0;
            held_int_reg     <= '0;
            held_valid_reg   <= 1'b0;
            held_shad_reg    <= 1'b0;
            held_present_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            shad_reg         <= shad_next;
            held_range_reg   <= held_range_next;
            held_int_reg     <= held_int_next;
            held_valid_reg   <= held_valid_next;
            held_shad_reg    <= held_shad_next;
            held_present_reg <= held_present_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        out_range_reg <= out_range_next;
        out_filt_reg  <= out_filt_next;
        out_int_reg   <= out_int_next;
        out_eos_reg   <= out_eos_next;
    end

endmodule

// ===== hw/rtl/laser_scan_shadow_filter_top.sv =====
// top level of the laser scan shadow filter: config registers, front, queue, back
// depends on lssf_pkg, lssf_front, lssf_queue, lssf_back (and lssf_shadow below it)
//
//  channel   direction  handshake                  payload
//  cfg       in         cfg_we                     cfg_index, cfg_data
//  s_axis    in         s_axis_tvalid/tready       tdata, tuser, tlast
//  m_axis    out        m_axis_tvalid/tready       tdata, tuser, tlast
//
// the front takes one input transaction per cycle while the 4-entry queue has room
// the back pops a sample in BK_IDLE and emits each result from BK_HELD or BK_CUR once the output register is free
// a neighbor test runs on the shared 32x32 multiplier sequencer, which ends at SH_CHK if degenerate
// so the back takes no new sample from the queue until a test and its result are through
// rst_n clears the index, queue, held sample and output valid; config returns to defaults
// a stalled m_axis holds the output register and backs up into the queue
module laser_scan_shadow_filter_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lssf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lssf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [lssf_pkg::TDATA_W-1:0]    s_axis_tdata,   // range_mm, intensity
    input  logic                            s_axis_tuser,   // no_return
    input  logic                            s_axis_tlast,   // last_sample
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [lssf_pkg::TDATA_W-1:0]    m_axis_tdata,   // out_range_mm, out_intensity
    output logic                            m_axis_tuser,   // filtered_out
    output logic                            m_axis_tlast    // end_of_scan
);
    import lssf_pkg::*;

    cfg_t               cfg_reg;
    logic               q_full;
    logic               q_empty;
    logic               push;
    logic               pop;
    item_t              push_item;
    item_t              head;
    logic [RANGE_W-1:0] out_range_mm;
    logic [INT_W-1:0]   out_intensity;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rng_lo    <= RST_RNG_LO;
            cfg_reg.rng_hi    <= RST_RNG_HI;
            cfg_reg.max_dist  <= RST_MAX_DIST;
            cfg_reg.win_first <= RST_WIN_FIRST;
            cfg_reg.win_last  <= RST_WIN_LAST;
            cfg_reg.cos_step  <= RST_COS_STEP;
            cfg_reg.threshold <= RST_THRESHOLD;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RNG_LO:    cfg_reg.rng_lo    <= cfg_data[RANGE_W-1:0];
                REG_RNG_HI:    cfg_reg.rng_hi    <= cfg_data[RANGE_W-1:0];
                REG_MAX_DIST:  cfg_reg.max_dist  <= cfg_data[RANGE_W-1:0];
                REG_WIN_FIRST: cfg_reg.win_first <= cfg_data[IDX_W-1:0];
                REG_WIN_LAST:  cfg_reg.win_last  <= cfg_data[IDX_W-1:0];
                REG_COS_STEP:  cfg_reg.cos_step  <= $signed(cfg_data[15:0]);
                REG_THRESHOLD: cfg_reg.threshold <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    lssf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .push          (push),
        .push_item     (push_item)
    );

    lssf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (head)
    );

    lssf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_empty       (q_empty),
        .head          (head),
        .pop           (pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_range_mm  (out_range_mm),
        .out_filtered  (m_axis_tuser),
        .out_intensity (out_intensity),
        .out_eos       (m_axis_tlast)
    );

    assign m_axis_tdata = {out_intensity, out_range_mm};

endmodule
